@@ sv/mbmd_pkg.sv @@
// Shared constants for the marker byte message deframer.
package mbmd_pkg;

  // Width of one link byte and of the minimum length register.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 7;

  // Framing codes.
  localparam logic [BYTE_W-1:0] START_LOW  = 8'h80;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'hFF;
  localparam logic [BYTE_W-1:0] BCAST_BYTE = 8'h81;

  // Minimum length after reset.
  localparam logic [CFG_W-1:0] MIN_LEN_RESET = 7'd15;

endpackage

@@ sv/mbmd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module mbmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data is captured while re_i is high.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/marker_byte_message_deframer_unit.sv @@
// Top level of the marker byte message deframer: framing, message RAM and replay.
//
// Usage: link bytes enter on the rx channel (rx_valid_i / rx_ready_o). While no
// message is open, bytes are dropped until a start byte (0x80 to 0xFE) arrives.
// From then on every byte is written to the message RAM until the end byte 0xFF.
// A finished message whose length, end byte included, is at least the configured
// minimum length is replayed on the msg channel (msg_valid_o / msg_ready_i), one
// transaction per byte, with last_o on the end byte and broadcast_o set for the
// whole message when its first byte is 0x81. Shorter messages are dropped, and a
// message that fills all MAX_LEN entries without an end byte is discarded.
// Throughput: the rx channel takes one byte per cycle while no message is replayed.
// Replay keeps a single outstanding read of the message RAM, so a byte is read only
// after the previous read has returned to the output register, and the rx channel
// stays blocked while a delivered message is replayed. A stalled receiver holds
// the output register; replay waits on it and the rx channel stays blocked until
// the last byte has been loaded into the register.
// Reset returns to the idle receive state with no message open, an empty output
// register and a minimum length of 15. The RAM content is not cleared.
module marker_byte_message_deframer_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: minimum message length.
  input  logic                        cfg_we_i,
  input  logic [mbmd_pkg::CFG_W-1:0]  cfg_wdata_i,
  // Received bytes.
  input  logic                        rx_valid_i,
  output logic                        rx_ready_o,
  input  logic [mbmd_pkg::BYTE_W-1:0] rx_byte_i,
  // Delivered message bytes.
  output logic                        msg_valid_o,
  input  logic                        msg_ready_i,
  output logic [mbmd_pkg::BYTE_W-1:0] msg_byte_o,
  output logic                        last_o,
  output logic                        broadcast_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);

  typedef enum logic {
    ST_RECV,
    ST_REPLAY
  } state_e;

  state_e                      state_q;
  logic [CNT_W-1:0]            fill_q;
  logic [CNT_W-1:0]            len_q;
  logic [CNT_W-1:0]            rd_cnt_q;
  logic                        rd_pend_q;
  logic                        rd_last_q;
  logic                        bcast_q;
  logic [mbmd_pkg::CFG_W-1:0]  min_len_q;
  logic                        out_valid_q;
  logic [mbmd_pkg::BYTE_W-1:0] out_byte_q;
  logic                        out_last_q;
  logic                        out_bcast_q;

  logic                        rx_acc;
  logic                        is_start;
  logic                        is_end;
  logic                        store_we;
  logic [CNT_W-1:0]            len_next;
  logic                        deliver;
  logic                        store_full;
  logic                        rd_issue;
  logic                        rd_all_issued;
  logic                        out_take;
  logic [mbmd_pkg::BYTE_W-1:0] rd_data;

  // Receive side decode.
  assign rx_ready_o = (state_q == ST_RECV);
  assign rx_acc     = rx_valid_i && rx_ready_o;
  assign is_start   = (rx_byte_i >= mbmd_pkg::START_LOW) && (rx_byte_i != mbmd_pkg::END_BYTE);
  assign is_end     = (rx_byte_i == mbmd_pkg::END_BYTE);
  assign store_we   = rx_acc && ((fill_q != '0) || is_start);
  assign len_next   = fill_q + CNT_W'(1);
  assign deliver    = is_end && (mbmd_pkg::CFG_W'(len_next) >= min_len_q);
  assign store_full = (len_next == CNT_W'(MAX_LEN));

  // Replay side: one read in flight, issued only when the output register frees up.
  assign out_take      = out_valid_q && msg_ready_i;
  assign rd_all_issued = (rd_cnt_q == len_q);
  assign rd_issue      = (state_q == ST_REPLAY) && !rd_all_issued && !rd_pend_q
                         && (!out_valid_q || msg_ready_i);

  mbmd_ram #(
    .WIDTH (mbmd_pkg::BYTE_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (rd_issue),
    .raddr_i (rd_cnt_q[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= mbmd_pkg::MIN_LEN_RESET;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  // Framing state, replay sequencing and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RECV;
      fill_q      <= '0;
      len_q       <= '0;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      bcast_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_bcast_q <= 1'b0;
    end else begin
      // The output register empties when the receiver takes the byte.
      if (out_take) begin
        out_valid_q <= 1'b0;
      end

      // Read data is loaded into the output register in the cycle after the read is issued.
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= rd_data;
        out_last_q  <= rd_last_q;
        out_bcast_q <= bcast_q;
      end
      rd_pend_q <= rd_issue;

      unique case (state_q)
        ST_RECV: begin
          if (store_we) begin
            if (fill_q == '0) begin
              bcast_q <= (rx_byte_i == mbmd_pkg::BCAST_BYTE);
            end
            if (is_end || store_full) begin
              fill_q <= '0;
            end else begin
              fill_q <= len_next;
            end
            if (deliver) begin
              state_q  <= ST_REPLAY;
              len_q    <= len_next;
              rd_cnt_q <= '0;
            end
          end
        end
        ST_REPLAY: begin
          if (rd_issue) begin
            rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
            rd_last_q <= ((rd_cnt_q + CNT_W'(1)) == len_q);
          end
          // Leave once the final read has returned into the output register.
          if (rd_pend_q && rd_all_issued) begin
            state_q <= ST_RECV;
          end
        end
        default: begin
          state_q <= ST_RECV;
        end
      endcase
    end
  end

  assign msg_valid_o = out_valid_q;
  assign msg_byte_o  = out_byte_q;
  assign last_o      = out_last_q;
  assign broadcast_o = out_bcast_q;

  // A returning read never overwrites a byte still held in the output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("read data would overwrite a pending output byte");

  // No byte is taken from the link while the final read of the store is outstanding.
  a_rx_blocked_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q && rd_all_issued |-> !rx_ready_o)
    else $error("rx accepted while replay still in flight");

  // The open message never holds the full store.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CNT_W'(MAX_LEN))
    else $error("fill count reached store depth");

  // The marked final byte of a message is always the end byte.
  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_valid_o && last_o |-> msg_byte_o == mbmd_pkg::END_BYTE)
    else $error("last marker on a byte other than the end byte");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the marker byte message deframer unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MAX_LEN       = 64;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_ITEMS  = 80;
  localparam int unsigned PHASE_ITEMS   = 8;

  // One expected transaction on the message channel.
  typedef struct packed {
    logic [mbmd_pkg::BYTE_W-1:0] data;
    logic                        is_last;
    logic                        bcast;
  } msg_beat_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we      = 1'b0;
  logic [mbmd_pkg::CFG_W-1:0]  cfg_wdata   = '0;
  logic                        rx_valid    = 1'b0;
  logic                        rx_ready_o;
  logic [mbmd_pkg::BYTE_W-1:0] rx_byte     = '0;
  logic                        msg_valid_o;
  logic                        msg_ready   = 1'b0;
  logic [mbmd_pkg::BYTE_W-1:0] msg_byte_o;
  logic                        last_o;
  logic                        broadcast_o;

  // Shadow copy of the deframer state.
  logic [mbmd_pkg::BYTE_W-1:0] shadow_store [MAX_LEN];
  int unsigned                 shadow_fill;
  int unsigned                 shadow_min_len;

  msg_beat_t   pending_beats [$];
  int unsigned n_sent;
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned hold_cycles;
  bit          gaps_on;

  marker_byte_message_deframer_unit #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .rx_valid_i (rx_valid),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte),
    .msg_valid_o(msg_valid_o),
    .msg_ready_i(msg_ready),
    .msg_byte_o (msg_byte_o),
    .last_o     (last_o),
    .broadcast_o(broadcast_o)
  );

  always #2 clk_i = ~clk_i;

  // Frame one accepted byte and queue the message bytes it releases.
  function automatic void deframe_byte(input logic [mbmd_pkg::BYTE_W-1:0] b);
    msg_beat_t beat;
    if (shadow_fill == 0 && !(b >= mbmd_pkg::START_LOW && b != mbmd_pkg::END_BYTE)) begin
      return;
    end
    shadow_store[shadow_fill] = b;
    shadow_fill++;
    if (b == mbmd_pkg::END_BYTE) begin
      if (shadow_fill >= shadow_min_len) begin
        for (int k = 0; k < shadow_fill; k++) begin
          beat.data    = shadow_store[k];
          beat.is_last = (k + 1 == shadow_fill);
          beat.bcast   = (shadow_store[0] == mbmd_pkg::BCAST_BYTE);
          pending_beats.push_back(beat);
        end
      end
      shadow_fill = 0;
    end
    // A store that fills up without an end byte drops the message.
    if (shadow_fill >= MAX_LEN) begin
      shadow_fill = 0;
    end
  endfunction

  // Offer one byte, after a random gap if gaps_on, and wait until it is accepted.
  task automatic send_byte(input logic [mbmd_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (rx_ready_o !== 1'b1);
    deframe_byte(b);
    n_sent++;
  endtask

  task automatic rx_go_idle();
    rx_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  // Send one message; an unterminated one stays open unless it fills the store.
  task automatic send_frame(input int unsigned len, input bit close);
    logic [mbmd_pkg::BYTE_W-1:0] b;
    int unsigned                 body;
    if ($urandom_range(0, 3) == 0) begin
      b = mbmd_pkg::BCAST_BYTE;
    end else begin
      b = 8'($urandom_range(mbmd_pkg::START_LOW, mbmd_pkg::END_BYTE - 8'd1));
    end
    send_byte(b);
    body = close ? len - 2 : len - 1;
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        b = 8'($urandom_range(mbmd_pkg::START_LOW, mbmd_pkg::END_BYTE - 8'd1));
      end else begin
        b = 8'($urandom_range(0, mbmd_pkg::END_BYTE - 8'd1));
      end
      send_byte(b);
    end
    if (close) begin
      send_byte(mbmd_pkg::END_BYTE);
    end
  endtask

  // Write the minimum length once no message is open and the block is quiet.
  task automatic write_min_length(input logic [mbmd_pkg::CFG_W-1:0] value);
    if (shadow_fill != 0) begin
      send_byte(mbmd_pkg::END_BYTE);
    end
    rx_go_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    shadow_min_len = 32'(value);
  endtask

  // Idle drops and a full message at the minimum length left by reset.
  task automatic test_default_length();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(mbmd_pkg::END_BYTE);
    send_byte(mbmd_pkg::BCAST_BYTE);
    send_byte(mbmd_pkg::END_BYTE - 8'd1);
    send_byte(mbmd_pkg::START_LOW);
    send_byte(8'h00);
    repeat (10) send_byte(8'($urandom_range(0, mbmd_pkg::END_BYTE - 8'd1)));
    send_byte(mbmd_pkg::END_BYTE);
  endtask

  // Short and exact-length messages, and a minimum length of one.
  task automatic test_length_limits();
    write_min_length(7'd3);
    send_byte(mbmd_pkg::END_BYTE - 8'd1);
    send_byte(mbmd_pkg::END_BYTE);
    send_byte(mbmd_pkg::START_LOW);
    send_byte(8'h00);
    send_byte(mbmd_pkg::END_BYTE);
    write_min_length(7'd1);
    send_byte(8'h82);
    send_byte(mbmd_pkg::END_BYTE);
  endtask

  // A message that just fits the store, and one that overflows it.
  task automatic test_store_full();
    write_min_length(7'(MAX_LEN));
    send_frame(MAX_LEN, 1'b1);
    send_frame(MAX_LEN, 1'b0);
    send_byte(8'h55);
    send_frame(2, 1'b1);
  endtask

  // The receiver holds off while the sender keeps offering bytes.
  task automatic test_output_backpressure();
    write_min_length(7'd2);
    gaps_on     = 1'b0;
    hold_cycles = LONG_HOLD;
    repeat (2) send_frame(16, 1'b1);
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed messages with random content, plus noise and broken frames.
  task automatic test_random_frames();
    int unsigned                first_sent;
    int unsigned                phase_start;
    int unsigned                phase;
    int unsigned                pick;
    int unsigned                len;
    logic [mbmd_pkg::CFG_W-1:0] min_choice;
    first_sent = n_sent;
    phase      = 0;
    while (n_sent - first_sent < RANDOM_ITEMS) begin
      case (phase % 8)
        0: min_choice = 7'd1;
        1: min_choice = 7'(MAX_LEN + 1);
        2: min_choice = 7'd0;
        3: min_choice = 7'($urandom_range(2, 12));
        4: min_choice = 7'(MAX_LEN);
        5: min_choice = 7'd127;
        6: min_choice = 7'($urandom_range(1, MAX_LEN));
        default: min_choice = 7'd2;
      endcase
      write_min_length(min_choice);
      gaps_on     = ($urandom_range(0, 3) != 0);
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (pick == 1) begin
          send_frame($urandom_range(2, 12), 1'b0);
        end else begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, MAX_LEN + 2)
                                            : $urandom_range(2, 16);
          send_frame(len, 1'b1);
        end
        // Now and then the sender waits for every pending byte to come out.
        if ($urandom_range(0, 15) == 0) begin
          rx_go_idle();
          wait_drained();
        end
      end
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  // Message channel sink: random stalls, then compare each transaction.
  initial begin : msg_sink
    msg_beat_t   want;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = gaps_on ? $urandom_range(0, 11) : 0;
      end
      if (stall != 0) begin
        msg_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      msg_ready <= 1'b1;
      do @(posedge clk_i); while (msg_valid_o !== 1'b1);
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected transaction byte=%02h last=%b broadcast=%b",
                 $time, msg_byte_o, last_o, broadcast_o);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (msg_byte_o !== want.data) begin
          $display("%0t: msg_byte expected %02h actual %02h", $time, want.data, msg_byte_o);
          errors++;
        end
        if (last_o !== want.is_last) begin
          $display("%0t: last expected %b actual %b", $time, want.is_last, last_o);
          errors++;
        end
        if (broadcast_o !== want.bcast) begin
          $display("%0t: broadcast expected %b actual %b", $time, want.bcast, broadcast_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction completes for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid && rx_ready_o === 1'b1) || (msg_valid_o === 1'b1 && msg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    n_sent         = 0;
    errors         = 0;
    idle_cycles    = 0;
    hold_cycles    = 0;
    gaps_on        = 1'b1;
    shadow_fill    = 0;
    shadow_min_len = 32'(mbmd_pkg::MIN_LEN_RESET);
    foreach (shadow_store[i]) shadow_store[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_length();
    test_length_limits();
    test_store_full();
    test_output_backpressure();
    test_random_frames();

    // Let the last message drain before judging the run.
    rx_go_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ marker_byte_message_deframer_unit.f @@
sv/mbmd_pkg.sv
sv/mbmd_ram.sv
sv/marker_byte_message_deframer_unit.sv
test/tb_top.sv
